// ----- rtl/bfha_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfha_pkg
// Shared types and constants of the best-fit heap allocator.
// ----------------------------------------------------------------------------
package bfha_pkg;

  localparam int DEF_HEAP_WORDS = 4096;
  localparam int SIZE_W = 16;
  localparam int INDEX_W = 12;
  localparam int NEED_W = 15;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NULL  = 2'd1,
    ST_OOM   = 2'd2,
    ST_DFREE = 2'd3
  } status_t;

endpackage

// ----- rtl/best_fit_heap_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_fit_heap_allocator
// Word-granular best-fit allocator over a chain of one-word chunk headers.
// ----------------------------------------------------------------------------
// A request beat is taken when start is high and busy is low. It carries
// req_type, size_bytes for an allocation and word_index for a free. Each
// request yields exactly one result beat, shown on status and payload_index
// for one cycle while done is high; the receiver cannot stall it.
// Chunk headers live in one RAM with a registered read, and the chain walk
// reads one header per cycle. A free or an out-of-memory answer gives its
// result beat after the last header read; a granted allocation writes the
// chunk header in S_AHDR first, and a split grant then also writes the
// remainder header in S_ASPLIT. The worst case walks about HEAP_WORDS/2
// chunks. A zero-size allocation or a null free answers in the next cycle
// and leaves busy low. Every other request holds busy high until its result
// beat, and a new request can be taken in that same cycle. After reset the
// block writes the first header in S_INIT, with busy high, and then waits
// for requests.
// ----------------------------------------------------------------------------
module best_fit_heap_allocator
  import bfha_pkg::*;
#(
  parameter int HEAP_WORDS = DEF_HEAP_WORDS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               req_type,
  input  logic [SIZE_W-1:0]  size_bytes,
  input  logic [INDEX_W-1:0] word_index,
  output logic               done,
  output logic [1:0]         status,
  output logic [INDEX_W-1:0] payload_index
);

  localparam int AW = $clog2(HEAP_WORDS);
  localparam int HW = AW + 1;
  localparam int CW = ((AW > NEED_W) ? AW : NEED_W) + 2;
  localparam logic [AW-1:0] LAST = AW'(HEAP_WORDS - 1);

  typedef enum logic [6:0] {
    S_INIT   = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_AWALK  = 7'b0000100,
    S_AHDR   = 7'b0001000,
    S_ASPLIT = 7'b0010000,
    S_FWALK  = 7'b0100000,
    S_FMERGE = 7'b1000000
  } state_t;

  state_t state;

  logic [AW-1:0]     pos;
  logic [AW-1:0]     target;
  logic [AW-1:0]     acc;
  logic [AW-1:0]     best_pos;
  logic [AW-1:0]     fit_len;
  logic              have;
  logic [NEED_W-1:0] need;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [HW-1:0]     wr_data;
  logic [AW-1:0]     rd_addr;
  logic [HW-1:0]     rd_data;

  logic              hdr_free;
  logic [AW-1:0]     hdr_len;
  logic              at_end;
  logic              fits;
  logic              exact;
  logic [AW-1:0]     step;
  logic [CW-1:0]     need_cw;
  logic [AW-1:0]     need_aw;
  logic [16:0]       bytes_rnd;
  logic [NEED_W-1:0] need_calc;
  logic [CW-1:0]     tgt_cw;
  logic              free_null;
  logic [CW-1:0]     pay_cw;
  logic              merge_end;

  bfha_ram #(
    .WIDTH(HW),
    .DEPTH(HEAP_WORDS)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign busy      = (state != S_IDLE);
  assign hdr_free  = rd_data[AW];
  assign hdr_len   = rd_data[AW-1:0];
  assign at_end    = (pos == LAST) || (hdr_len == '0);
  assign need_cw   = CW'(need);
  assign need_aw   = need_cw[AW-1:0];
  assign fits      = hdr_free && (CW'(hdr_len) >= need_cw) && (!have || hdr_len <= fit_len);
  assign exact     = (CW'(hdr_len) == need_cw);
  assign step      = pos + hdr_len;
  assign bytes_rnd = {1'b0, size_bytes} + 17'd3;
  assign need_calc = bytes_rnd[16:2] + NEED_W'(1);
  assign tgt_cw    = CW'(word_index) - CW'(1);
  assign free_null = (word_index == '0) || (tgt_cw >= CW'(HEAP_WORDS - 1));
  assign pay_cw    = CW'(best_pos) + CW'(1);
  assign merge_end = at_end || !hdr_free;
  assign rd_addr   = (state == S_IDLE) ? '0 : step;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    unique case (state)
      S_INIT: begin
        wr_en   = 1'b1;
        wr_data = {1'b1, LAST};
      end
      S_AHDR: begin
        wr_en   = 1'b1;
        wr_addr = best_pos;
        wr_data = {1'b0, need_aw};
      end
      S_ASPLIT: begin
        wr_en   = 1'b1;
        wr_addr = best_pos + need_aw;
        wr_data = {1'b1, fit_len - need_aw};
      end
      S_FMERGE: begin
        wr_en   = merge_end;
        wr_addr = target;
        wr_data = {1'b1, acc};
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      done  <= 1'b0;
      have  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_INIT: begin
          state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            pos    <= '0;
            have   <= 1'b0;
            need   <= need_calc;
            target <= tgt_cw[AW-1:0];
            if (req_type == REQ_ALLOC) begin
              if (size_bytes == '0) begin
                done          <= 1'b1;
                status        <= ST_NULL;
                payload_index <= '0;
              end else begin
                state <= S_AWALK;
              end
            end else if (free_null) begin
              done          <= 1'b1;
              status        <= ST_NULL;
              payload_index <= '0;
            end else begin
              state <= S_FWALK;
            end
          end
        end
        S_AWALK: begin
          if (at_end) begin
            if (have) begin
              state <= S_AHDR;
            end else begin
              done          <= 1'b1;
              status        <= ST_OOM;
              payload_index <= '0;
              state         <= S_IDLE;
            end
          end else begin
            pos <= step;
            if (fits) begin
              have     <= 1'b1;
              best_pos <= pos;
              fit_len  <= hdr_len;
              if (exact) begin
                state <= S_AHDR;
              end
            end
          end
        end
        S_AHDR: begin
          if (fit_len != need_aw) begin
            state <= S_ASPLIT;
          end else begin
            done          <= 1'b1;
            status        <= ST_OK;
            payload_index <= pay_cw[INDEX_W-1:0];
            state         <= S_IDLE;
          end
        end
        S_ASPLIT: begin
          done          <= 1'b1;
          status        <= ST_OK;
          payload_index <= pay_cw[INDEX_W-1:0];
          state         <= S_IDLE;
        end
        S_FWALK: begin
          if (pos >= target) begin
            if (pos != target || at_end) begin
              done          <= 1'b1;
              status        <= ST_NULL;
              payload_index <= '0;
              state         <= S_IDLE;
            end else if (hdr_free) begin
              done          <= 1'b1;
              status        <= ST_DFREE;
              payload_index <= '0;
              state         <= S_IDLE;
            end else begin
              acc   <= hdr_len;
              pos   <= step;
              state <= S_FMERGE;
            end
          end else if (at_end) begin
            done          <= 1'b1;
            status        <= ST_NULL;
            payload_index <= '0;
            state         <= S_IDLE;
          end else begin
            pos <= step;
          end
        end
        S_FMERGE: begin
          if (merge_end) begin
            done          <= 1'b1;
            status        <= ST_OK;
            payload_index <= '0;
            state         <= S_IDLE;
          end else begin
            acc <= acc + hdr_len;
            pos <= step;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A result beat is shown only while the block is idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result beat while busy");

  // Only a successful allocation returns a nonzero index.
  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> payload_index == '0)
    else $error("nonzero index on a failed request");

  // An accepted request either starts work or answers at once.
  a_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("request beat dropped");

  // The header write only happens after a fit was found.
  a_have: assert property (@(posedge clk) disable iff (rst) (state == S_AHDR) |-> have)
    else $error("chunk header written without a fit");

  // A split always leaves a nonempty remainder.
  a_split: assert property (@(posedge clk) disable iff (rst)
    (state == S_ASPLIT) |-> (fit_len > need_aw))
    else $error("split with no remainder");

endmodule

// ----- rtl/bfha_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfha_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module bfha_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- bench/best_fit_heap_allocator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_fit_heap_allocator_tb
// Self-checking regression of the best-fit heap allocator.
// ----------------------------------------------------------------------------
// A short directed table covers zero-size and oversized allocations, a
// full-heap grant, null, stray and double frees, exact fits, forward merges
// and the tie between equal-size chunks. Random allocate and free traffic
// follows. Typed rows carry their expected outcome, a shadow heap of chunk
// headers predicts the rest, and the result beats are compared in order.
// ----------------------------------------------------------------------------
module best_fit_heap_allocator_tb;
  import bfha_pkg::*;

  localparam int HEAP = DEF_HEAP_WORDS;
  localparam int QUIET_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 265;

  typedef struct packed {
    logic        free;
    logic [12:0] len;
  } chunk_hdr_t;

  typedef struct packed {
    status_t            st;
    logic [INDEX_W-1:0] pidx;
  } outcome_t;

  typedef struct packed {
    req_t               kind;
    logic [SIZE_W-1:0]  bytes;
    logic [INDEX_W-1:0] widx;
    logic               typed;
    status_t            st;
    logic [INDEX_W-1:0] pidx;
  } plan_row_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic               req_type;
  logic [SIZE_W-1:0]  size_bytes;
  logic [INDEX_W-1:0] word_index;
  logic               done;
  logic [1:0]         status;
  logic [INDEX_W-1:0] payload_index;

  chunk_hdr_t         heap_hdr [HEAP];
  outcome_t           outcome_q [$];
  outcome_t           exp_now;
  plan_row_t          plan [$];
  logic [INDEX_W-1:0] live_blocks [$];
  logic [INDEX_W-1:0] released_blocks [$];
  int                 errors;
  int                 checked;
  int                 quiet_cycles;
  int                 tally [4];
  bit                 idle_on;

  best_fit_heap_allocator u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .req_type      (req_type),
    .size_bytes    (size_bytes),
    .word_index    (word_index),
    .done          (done),
    .status        (status),
    .payload_index (payload_index)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic report_mismatch(input string what);
    errors++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic void heap_alloc(input logic [SIZE_W-1:0] bytes, output status_t st,
                                     output logic [INDEX_W-1:0] pidx);
    int need;
    int pos;
    int len;
    int best_pos;
    int fit_len;
    bit found;
    bit exact;
    st = ST_NULL;
    pidx = '0;
    if (bytes != 0) begin
      need = ((int'(bytes) + 3) >> 2) + 1;
      pos = 0;
      best_pos = 0;
      fit_len = 0;
      found = 1'b0;
      exact = 1'b0;
      while (pos < HEAP && !exact && heap_hdr[pos].len != 0) begin
        len = int'(heap_hdr[pos].len);
        if (heap_hdr[pos].free && len >= need && (!found || len <= fit_len)) begin
          found = 1'b1;
          best_pos = pos;
          fit_len = len;
          exact = (len == need);
        end
        pos += len;
      end
      if (!found) begin
        st = ST_OOM;
      end else begin
        heap_hdr[best_pos].free = 1'b0;
        heap_hdr[best_pos].len = 13'(need);
        if (fit_len > need && best_pos + need < HEAP) begin
          heap_hdr[best_pos + need].free = 1'b1;
          heap_hdr[best_pos + need].len = 13'(fit_len - need);
        end
        st = ST_OK;
        pidx = INDEX_W'(best_pos + 1);
      end
    end
  endfunction

  function automatic status_t heap_free(input logic [INDEX_W-1:0] widx);
    int target;
    int pos;
    int len;
    bit merging;
    status_t st;
    st = ST_NULL;
    if (widx != 0 && int'(widx) <= HEAP) begin
      target = int'(widx) - 1;
      pos = 0;
      len = 1;
      while (pos < target && pos < HEAP && len != 0) begin
        len = int'(heap_hdr[pos].len);
        pos += len;
      end
      if (pos == target && heap_hdr[target].len != 0) begin
        if (heap_hdr[target].free) begin
          st = ST_DFREE;
        end else begin
          len = int'(heap_hdr[target].len);
          merging = 1'b1;
          while (merging && target + len < HEAP) begin
            if (heap_hdr[target + len].free && heap_hdr[target + len].len != 0) begin
              len += int'(heap_hdr[target + len].len);
            end else begin
              merging = 1'b0;
            end
          end
          heap_hdr[target].free = 1'b1;
          heap_hdr[target].len = 13'(len);
          st = ST_OK;
        end
      end
    end
    return st;
  endfunction

  function automatic void predict_request(input req_t kind, input logic [SIZE_W-1:0] bytes,
                                          input logic [INDEX_W-1:0] widx,
                                          output status_t st,
                                          output logic [INDEX_W-1:0] pidx);
    if (kind == REQ_ALLOC) begin
      heap_alloc(bytes, st, pidx);
    end else begin
      st = heap_free(widx);
      pidx = '0;
    end
  endfunction

  function automatic plan_row_t row(input req_t kind, input int bytes, input int widx,
                                    input bit typed, input status_t st, input int pidx);
    plan_row_t r;
    r.kind = kind;
    r.bytes = SIZE_W'(bytes);
    r.widx = INDEX_W'(widx);
    r.typed = typed;
    r.st = st;
    r.pidx = INDEX_W'(pidx);
    return r;
  endfunction

  task automatic issue(input req_t kind, input logic [SIZE_W-1:0] bytes,
                       input logic [INDEX_W-1:0] widx, input bit typed,
                       input status_t want_st, input logic [INDEX_W-1:0] want_idx,
                       output status_t st, output logic [INDEX_W-1:0] pidx);
    int gap;
    outcome_t o;
    if (idle_on && $urandom_range(0, 99) < 27) begin
      start = 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(negedge clk);
    end
    start = 1'b1;
    req_type = kind;
    size_bytes = bytes;
    word_index = widx;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_request(kind, bytes, widx, st, pidx);
    tally[st]++;
    o.st = typed ? want_st : st;
    o.pidx = typed ? want_idx : pidx;
    outcome_q.push_back(o);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (done) begin
        if (outcome_q.size() == 0) begin
          report_mismatch("result beat with no request outstanding");
        end else begin
          exp_now = outcome_q.pop_front();
          checked++;
          if (status !== exp_now.st)
            report_mismatch($sformatf("status got %0d want %0d", status, exp_now.st));
          if (payload_index !== exp_now.pidx)
            report_mismatch($sformatf("payload_index got %0d want %0d",
                                      payload_index, exp_now.pidx));
        end
      end
      if ((start && !busy) || done) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
        $display("best_fit_heap_allocator regression: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    status_t            st;
    logic [INDEX_W-1:0] pidx;
    req_t               kind;
    logic [SIZE_W-1:0]  bytes;
    logic [INDEX_W-1:0] widx;
    int                 pick;
    int                 k;
    errors = 0;
    checked = 0;
    idle_on = 1'b1;
    for (int i = 0; i < 4; i++) tally[i] = 0;
    rst = 1'b1;
    start = 1'b0;
    req_type = REQ_ALLOC;
    size_bytes = '0;
    word_index = '0;
    for (int i = 0; i < HEAP; i++) heap_hdr[i] = '0;
    heap_hdr[0].free = 1'b1;
    heap_hdr[0].len = 13'(HEAP - 1);

    plan.push_back(row(REQ_ALLOC, 0, 0, 1, ST_NULL, 0));
    plan.push_back(row(REQ_FREE, 0, 0, 1, ST_NULL, 0));
    plan.push_back(row(REQ_ALLOC, 65535, 4095, 1, ST_OOM, 0));
    plan.push_back(row(REQ_ALLOC, 16376, 0, 1, ST_OK, 1));
    plan.push_back(row(REQ_ALLOC, 1, 0, 1, ST_OOM, 0));
    plan.push_back(row(REQ_FREE, 65535, 1, 1, ST_OK, 0));
    plan.push_back(row(REQ_FREE, 0, 1, 1, ST_DFREE, 0));
    plan.push_back(row(REQ_FREE, 0, 4095, 1, ST_NULL, 0));
    plan.push_back(row(REQ_ALLOC, 1, 0, 1, ST_OK, 1));
    plan.push_back(row(REQ_ALLOC, 4, 0, 0, ST_OK, 0));
    plan.push_back(row(REQ_ALLOC, 5, 0, 0, ST_OK, 0));
    plan.push_back(row(REQ_ALLOC, 8, 0, 0, ST_OK, 0));
    plan.push_back(row(REQ_FREE, 0, 3, 0, ST_OK, 0));
    plan.push_back(row(REQ_FREE, 0, 2, 1, ST_NULL, 0));
    plan.push_back(row(REQ_FREE, 0, 8, 0, ST_OK, 0));
    plan.push_back(row(REQ_ALLOC, 4, 0, 0, ST_OK, 0));
    plan.push_back(row(REQ_FREE, 0, 5, 0, ST_OK, 0));
    plan.push_back(row(REQ_ALLOC, 12, 0, 0, ST_OK, 0));
    plan.push_back(row(REQ_ALLOC, 4, 0, 0, ST_OK, 0));
    plan.push_back(row(REQ_ALLOC, 12, 0, 0, ST_OK, 0));
    plan.push_back(row(REQ_ALLOC, 4, 0, 0, ST_OK, 0));
    plan.push_back(row(REQ_FREE, 0, 5, 0, ST_OK, 0));
    plan.push_back(row(REQ_FREE, 0, 11, 0, ST_OK, 0));
    plan.push_back(row(REQ_ALLOC, 8, 0, 0, ST_OK, 0));
    plan.push_back(row(REQ_ALLOC, 9, 0, 0, ST_OK, 0));

    repeat (10) @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) begin
      issue(plan[i].kind, plan[i].bytes, plan[i].widx, plan[i].typed, plan[i].st,
            plan[i].pidx, st, pidx);
      if (plan[i].kind == REQ_ALLOC && st == ST_OK) live_blocks.push_back(pidx);
    end

    // Mostly well-formed traffic: small allocations and frees of live blocks,
    // with stale frees and random noise mixed in.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      idle_on = !(n >= 90 && n < 150);
      pick = $urandom_range(0, 99);
      kind = REQ_ALLOC;
      bytes = SIZE_W'($urandom);
      widx = INDEX_W'($urandom);
      if (pick < 45 || (pick < 85 && live_blocks.size() == 0)) begin
        k = $urandom_range(0, 99);
        if (k < 3) bytes = '0;
        else if (k < 20) bytes = SIZE_W'($urandom_range(65, 2048));
        else if (k >= 8) bytes = SIZE_W'($urandom_range(1, 64));
      end else if (pick < 85) begin
        kind = REQ_FREE;
        k = $urandom_range(0, live_blocks.size() - 1);
        widx = live_blocks[k];
        live_blocks.delete(k);
        released_blocks.push_back(widx);
      end else if (pick < 92 && released_blocks.size() != 0) begin
        kind = REQ_FREE;
        widx = released_blocks[$urandom_range(0, released_blocks.size() - 1)];
      end else begin
        kind = req_t'($urandom_range(0, 1));
      end
      issue(kind, bytes, widx, 1'b0, ST_OK, '0, st, pidx);
      if (kind == REQ_ALLOC && st == ST_OK) live_blocks.push_back(pidx);
    end
    start = 1'b0;

    while (outcome_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (outcome_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", outcome_q.size()));

    $display("Requests: %0d granted or freed, %0d out of memory, %0d double frees, %0d null.",
             tally[ST_OK], tally[ST_OOM], tally[ST_DFREE], tally[ST_NULL]);
    $display("Result beats checked: %0d, mismatches: %0d.", checked, errors);
    if (errors == 0) begin
      $display("best_fit_heap_allocator regression: pass");
    end else begin
      $display("best_fit_heap_allocator regression: fail");
    end
    $finish;
  end

endmodule
